[rtl/drs_pkg.sv]
// Shared types and constants for the exponent/mantissa rate search.
// Used by drs_ctrl, drs_datapath and data_rate_exponent_mantissa_search.
package drs_pkg;

	localparam int unsigned OSC_W   = 32;
	localparam int unsigned TGT_W   = 32;
	localparam int unsigned EXP_W   = 4;
	localparam int unsigned MANT_W  = 8;
	localparam int unsigned PAIR_W  = EXP_W + MANT_W;
	localparam int unsigned RATE_W  = 28;
	localparam int unsigned SCALE_W = MANT_W + 1;
	localparam int unsigned PROD_W  = SCALE_W + OSC_W;
	localparam int unsigned SHIFT_W = PROD_W + (1 << EXP_W) - 1;
	localparam int unsigned FRAC_W  = 28;

	localparam logic [OSC_W-1:0]  OSC_RESET = 32'd26000000;
	localparam logic [PAIR_W-1:0] PAIR_LAST = {PAIR_W{1'b1}};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DRAIN,
		ST_FINISH
	} drs_state_t;

	typedef struct packed {
		logic start;
		logic issue;
		logic load_out;
	} drs_cmd_t;

	typedef struct packed {
		logic last_pair;
		logic pipe_busy;
		logic out_free;
	} drs_status_t;

endpackage

[rtl/drs_ctrl.sv]
// Controller state machine for the rate search: sequences one request.
// Depends on drs_pkg for the state, command and status types.
module drs_ctrl
	import drs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  drs_status_t status,
	output drs_cmd_t    cmd
);

	drs_state_t state_q;
	drs_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_SEARCH;
			end
			ST_SEARCH: begin
				if (status.last_pair) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!status.pipe_busy) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall  = 1'b0;
				cmd.start = in_valid;
			end
			ST_SEARCH: begin
				cmd.issue = 1'b1;
			end
			ST_FINISH: begin
				cmd.load_out = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

[rtl/drs_datapath.sv]
// Datapath for the rate search: pair counter, rate pipeline, best-pair
// tracker and output register. Depends on drs_pkg.
module drs_datapath
	import drs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [OSC_W-1:0]    cfg_wr_data,
	input  logic [TGT_W-1:0]    target_rate,
	input  drs_cmd_t            cmd,
	output drs_status_t         status,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [EXP_W-1:0]    rate_exponent,
	output logic [MANT_W-1:0]   rate_mantissa,
	output logic [RATE_W-1:0]   achieved_rate
);

	logic [OSC_W-1:0]   osc_q;
	logic [TGT_W-1:0]   target_q;
	logic [PAIR_W-1:0]  pair_q;

	logic               v_s1, v_s2, v_s3;
	logic [EXP_W-1:0]   e_s1, e_s2, e_s3;
	logic [MANT_W-1:0]  m_s1, m_s2, m_s3;
	logic [PROD_W-1:0]  prod_s1;
	logic [RATE_W-1:0]  rate_s2, rate_s3;
	logic [TGT_W-1:0]   err_s3;

	logic               have_q;
	logic [TGT_W-1:0]   min_err_q;
	logic [EXP_W-1:0]   best_e_q;
	logic [MANT_W-1:0]  best_m_q;
	logic [RATE_W-1:0]  best_rate_q;

	logic               out_valid_q;
	logic [EXP_W-1:0]   out_e_q;
	logic [MANT_W-1:0]  out_m_q;
	logic [RATE_W-1:0]  out_rate_q;

	logic [SHIFT_W-1:0] shifted;
	logic [TGT_W-1:0]   rate_ext;
	logic               better;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			osc_q <= OSC_RESET;
		end else if (cfg_wr_en) begin
			osc_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			target_q <= target_rate;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_q <= '0;
		end else if (cmd.start) begin
			pair_q <= '0;
		end else if (cmd.issue) begin
			pair_q <= pair_q + 1'b1;
		end
	end

	// Stage 1: mantissa scale times the oscillator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		e_s1    <= pair_q[PAIR_W-1:MANT_W];
		m_s1    <= pair_q[MANT_W-1:0];
		prod_s1 <= {1'b1, pair_q[MANT_W-1:0]} * osc_q;
	end

	// Stage 2: exponent shift and drop of the fraction bits.
	assign shifted = {{(SHIFT_W-PROD_W){1'b0}}, prod_s1} << e_s1;

	always_ff @(posedge clk) begin
		e_s2    <= e_s1;
		m_s2    <= m_s1;
		rate_s2 <= shifted[FRAC_W +: RATE_W];
	end

	// Stage 3: absolute error against the request.
	assign rate_ext = {{(TGT_W-RATE_W){1'b0}}, rate_s2};

	always_ff @(posedge clk) begin
		e_s3    <= e_s2;
		m_s3    <= m_s2;
		rate_s3 <= rate_s2;
		err_s3  <= (rate_ext > target_q) ? (rate_ext - target_q) : (target_q - rate_ext);
	end

	// Best pair; strict compare keeps the earliest pair on a tie.
	assign better = v_s3 && (!have_q || (err_s3 < min_err_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (cmd.start) begin
			have_q <= 1'b0;
		end else if (better) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (better) begin
			min_err_q   <= err_s3;
			best_e_q    <= e_s3;
			best_m_q    <= m_s3;
			best_rate_q <= rate_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_e_q    <= best_e_q;
			out_m_q    <= best_m_q;
			out_rate_q <= best_rate_q;
		end
	end

	assign status.last_pair = cmd.issue && (pair_q == PAIR_LAST);
	assign status.pipe_busy = v_s1 | v_s2 | v_s3;
	assign status.out_free  = !out_valid_q || !out_stall;

	assign out_valid     = out_valid_q;
	assign rate_exponent = out_e_q;
	assign rate_mantissa = out_m_q;
	assign achieved_rate = out_rate_q;

endmodule

[rtl/data_rate_exponent_mantissa_search.sv]
// Top level of the exponent/mantissa rate search.
// Instantiates drs_ctrl and drs_datapath; types come from drs_pkg.
//
//   Channel   Direction  Handshake            Beat contents
//   in        input      in_valid/in_stall    target_rate
//   out       output     out_valid/out_stall  rate_exponent, rate_mantissa,
//                                             achieved_rate
//   cfg       input      cfg_wr_en            cfg_wr_data (oscillator_hz)
//
// A request's result beat is offered after the pair counter has walked all 4096
// exponent/mantissa pairs at one pair a cycle through a three-stage rate
// pipeline, the controller has drained that pipeline and the output register
// has been loaded. The next request is taken in the idle state that follows
// the load, so a new request is not accepted before the last one is through.
// Reset clears the controller, the pipeline valid bits and the output
// valid flag, and loads the oscillator register with 26 MHz.
// A stalled output beat holds in the output register; the next request
// is still taken and searched, and its result waits until that slot frees.

// The controller sequences start, issue and output load; the datapath holds
// the oscillator register, the multiplier pipeline and the best-pair tracker.
// The search keeps the first pair whose absolute error is the smallest, so
// ties go to the lower exponent and then the lower mantissa.
module data_rate_exponent_mantissa_search
	import drs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [OSC_W-1:0]    cfg_wr_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [TGT_W-1:0]    target_rate,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [EXP_W-1:0]    rate_exponent,
	output logic [MANT_W-1:0]   rate_mantissa,
	output logic [RATE_W-1:0]   achieved_rate
);

	drs_cmd_t    cmd;
	drs_status_t status;

	// Controller: one request at a time, accepted only in its idle state.
	drs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath: the request is captured on the start command and compared
	// against every candidate rate as it leaves the pipeline.
	drs_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.target_rate   (target_rate),
		.cmd           (cmd),
		.status        (status),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.rate_exponent (rate_exponent),
		.rate_mantissa (rate_mantissa),
		.achieved_rate (achieved_rate)
	);

endmodule
